@@ sv/mlpt_pkg.sv @@
// Shared types and codes of the multilevel page table.
// Standalone package: used by multilevel_page_table.
package mlpt_pkg;

  localparam int unsigned VADDR_W    = 32;
  localparam int unsigned FRAME_W    = 20;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 4;

  // Request kinds
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // Result status codes
  localparam logic [1:0] STAT_INSERTED  = 2'd0;
  localparam logic [1:0] STAT_HIT       = 2'd1;
  localparam logic [1:0] STAT_MISS      = 2'd2;
  localparam logic [1:0] STAT_POOL_FULL = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_LEVELS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_BITS_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_BITS_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_BITS_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_BITS_3 = 3'd4;

  typedef struct packed {
    logic               req_type;
    logic [VADDR_W-1:0] logical_address;
    logic [FRAME_W-1:0] frame_in;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [FRAME_W-1:0] frame_out;
  } rsp_t;

endpackage

@@ sv/mlpt_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mlpt_ram #(
  parameter int unsigned WIDTH = 21,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ sv/multilevel_page_table.sv @@
// Multilevel radix page table: sequencer, configuration registers, entry store.
// Depends on mlpt_pkg and mlpt_ram.
//
// Usage: after reset the block clears its entry store, one entry a cycle, all
// NODE_POOL * 2^MAX_LEVEL_BITS entries (16384 by default) with busy high. A
// request is taken when start is high and busy is low; busy then stays high
// until the single result is strobed on done_o for one cycle, which the
// receiver must take. Every level of a lookup costs one read of the single
// entry store, whose read data is registered. An insert follows the existing
// links, reads the first missing link if there is one (no leaf entry is read)
// and checks the node pool; if there is room, it writes one entry per fresh
// node plus the leaf.
// Configuration writes are always taken, but belong only in idle periods.
module multilevel_page_table
  import mlpt_pkg::*;
#(
  parameter int unsigned NODE_POOL      = 64,
  parameter int unsigned MAX_LEVEL_BITS = 8,
  parameter int unsigned MAX_LEVELS     = 4,
  parameter int unsigned FRAME_BITS     = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  req_t                  req_i,
  output logic                  done_o,
  output rsp_t                  rsp_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned NODE_W  = $clog2(NODE_POOL);
  localparam int unsigned CNT_W   = $clog2(NODE_POOL + 1);
  localparam int unsigned SUM_W   = ((CNT_W > 3) ? CNT_W : 3) + 1;
  localparam int unsigned FW      = (FRAME_BITS < FRAME_W) ? FRAME_BITS : FRAME_W;
  localparam int unsigned PW      = (FW > NODE_W) ? FW : NODE_W;
  localparam int unsigned DEPTH   = NODE_POOL * (2 ** MAX_LEVEL_BITS);
  localparam int unsigned SADDR_W = NODE_W + MAX_LEVEL_BITS;
  localparam int unsigned MLB     = MAX_LEVEL_BITS;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_EVAL,
    S_CHECK,
    S_WRITE
  } state_e;

  state_e                 state_q, state_d;
  logic [2:0]             num_levels_q, num_levels_d;
  logic [3:0]             level_bits_q [4];
  logic [3:0]             level_bits_d [4];
  logic [SADDR_W-1:0]     clr_q, clr_d;
  logic [VADDR_W-1:0]     sh_q, sh_d;
  logic [2:0]             lvl_q, lvl_d;
  logic [NODE_W-1:0]      node_q, node_d;
  logic [CNT_W-1:0]       next_free_q, next_free_d;
  logic                   req_type_q, req_type_d;
  logic [FRAME_W-1:0]     frame_q, frame_d;
  logic                   done_q, done_d;
  rsp_t                   rsp_q, rsp_d;

  logic [2:0]             n_eff, n_m1;
  logic [3:0]             lb_raw, w;
  logic [MLB-1:0]         idx;
  logic [SADDR_W-1:0]     slot;
  logic                   interior;
  logic                   link_ok;
  logic [SUM_W-1:0]       need;
  logic                   ram_we;
  logic [SADDR_W-1:0]     ram_waddr;
  logic [PW:0]            ram_wdata;
  logic [PW:0]            ram_rdata;

  // Effective level count and the width of the current level
  always_comb begin
    n_eff = num_levels_q;
    if (num_levels_q == 3'd0) begin
      n_eff = 3'd1;
    end else if ({1'b0, num_levels_q} > 4'(MAX_LEVELS)) begin
      n_eff = 3'(MAX_LEVELS);
    end
    n_m1 = n_eff - 3'd1;

    lb_raw = (lvl_q < 3'd4) ? level_bits_q[lvl_q[1:0]] : level_bits_q[3];
    w = lb_raw;
    if (lb_raw == 4'd0) begin
      w = 4'd1;
    end else if (lb_raw > 4'(MLB)) begin
      w = 4'(MLB);
    end
  end

  // Index bits of the current level sit at the top of the shifted address
  assign idx      = sh_q[VADDR_W-1 -: MLB] >> (4'(MLB) - w);
  assign slot     = {node_q, idx};
  assign interior = (lvl_q < n_m1);
  assign link_ok  = ram_rdata[PW] && ({1'b0, ram_rdata[PW-1:0]} < (PW+1)'(NODE_POOL));
  assign need     = SUM_W'(next_free_q) + SUM_W'(n_m1 - lvl_q);

  always_comb begin
    state_d      = state_q;
    num_levels_d = num_levels_q;
    level_bits_d = level_bits_q;
    clr_d        = clr_q;
    sh_d         = sh_q;
    lvl_d        = lvl_q;
    node_d       = node_q;
    next_free_d  = next_free_q;
    req_type_d   = req_type_q;
    frame_d      = frame_q;
    done_d       = 1'b0;
    rsp_d        = rsp_q;
    ram_we       = 1'b0;
    ram_waddr    = slot;
    ram_wdata    = '0;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_NUM_LEVELS:   num_levels_d    = cfg_data_i[2:0];
        CFG_LEVEL_BITS_0: level_bits_d[0] = cfg_data_i;
        CFG_LEVEL_BITS_1: level_bits_d[1] = cfg_data_i;
        CFG_LEVEL_BITS_2: level_bits_d[2] = cfg_data_i;
        CFG_LEVEL_BITS_3: level_bits_d[3] = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + SADDR_W'(1);
        if (clr_q == SADDR_W'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          sh_d       = req_i.logical_address;
          req_type_d = req_i.req_type;
          frame_d    = req_i.frame_in;
          lvl_d      = 3'd0;
          node_d     = '0;
          state_d    = S_WALK;
        end
      end
      S_WALK: begin
        // Insert needs no read of the leaf entry
        if (req_type_q == REQ_INSERT && !interior) begin
          state_d = S_CHECK;
        end else begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (interior) begin
          if (link_ok) begin
            node_d  = ram_rdata[NODE_W-1:0];
            sh_d    = sh_q << w;
            lvl_d   = lvl_q + 3'd1;
            state_d = S_WALK;
          end else if (req_type_q == REQ_LOOKUP) begin
            rsp_d.status    = STAT_MISS;
            rsp_d.frame_out = '0;
            done_d          = 1'b1;
            state_d         = S_IDLE;
          end else begin
            state_d = S_CHECK;
          end
        end else begin
          rsp_d.status    = ram_rdata[PW] ? STAT_HIT : STAT_MISS;
          rsp_d.frame_out = ram_rdata[PW] ? FRAME_W'(ram_rdata[FW-1:0]) : '0;
          done_d          = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_CHECK: begin
        if (need > SUM_W'(NODE_POOL)) begin
          rsp_d.status    = STAT_POOL_FULL;
          rsp_d.frame_out = '0;
          done_d          = 1'b1;
          state_d         = S_IDLE;
        end else begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        ram_we = 1'b1;
        if (interior) begin
          // Link a fresh node and descend into it
          ram_wdata   = {1'b1, PW'(next_free_q[NODE_W-1:0])};
          node_d      = next_free_q[NODE_W-1:0];
          next_free_d = next_free_q + CNT_W'(1);
          sh_d        = sh_q << w;
          lvl_d       = lvl_q + 3'd1;
        end else begin
          ram_wdata       = {1'b1, PW'(frame_q[FW-1:0])};
          rsp_d.status    = STAT_INSERTED;
          rsp_d.frame_out = '0;
          done_d          = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_CLEAR;
      num_levels_q    <= 3'd2;
      level_bits_q[0] <= 4'd8;
      level_bits_q[1] <= 4'd8;
      level_bits_q[2] <= 4'd8;
      level_bits_q[3] <= 4'd8;
      clr_q           <= '0;
      sh_q            <= '0;
      lvl_q           <= '0;
      node_q          <= '0;
      next_free_q     <= CNT_W'(1);
      req_type_q      <= REQ_INSERT;
      frame_q         <= '0;
      done_q          <= 1'b0;
      rsp_q           <= '0;
    end else begin
      state_q      <= state_d;
      num_levels_q <= num_levels_d;
      level_bits_q <= level_bits_d;
      clr_q        <= clr_d;
      sh_q         <= sh_d;
      lvl_q        <= lvl_d;
      node_q       <= node_d;
      next_free_q  <= next_free_d;
      req_type_q   <= req_type_d;
      frame_q      <= frame_d;
      done_q       <= done_d;
      rsp_q        <= rsp_d;
    end
  end

  mlpt_ram #(
    .WIDTH (PW + 1),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (slot),
    .rdata_o (ram_rdata)
  );

  assign busy        = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign rsp_o       = rsp_q;
  assign cfg_ready_o = 1'b1;

endmodule
